### hw/rtl/tsfp_pkg.sv
// ============================================================================
// tsfp_pkg: shared types and constants of the tracker serial frame parser
// Holds the parse phases, result codes, the event record that the parser
// front end hands to the frame arithmetic back end, and queue sizing.
// ============================================================================
package tsfp_pkg;

    // Frame layout: x word, y word, counter word.
    localparam int unsigned WORDS_PER_FRAME = 3;
    localparam logic [1:0]  LAST_WORD       = 2'(WORDS_PER_FRAME - 1);

    localparam logic [7:0]  HDR_BYTE = 8'h44;
    localparam logic [15:0] HDR_WORD = 16'h4444;

    // Signed division by ten: q = (w * 26215) >>> 18, plus one when w < 0.
    localparam logic signed [16:0] DIV_MAGIC = 17'sd26215;
    localparam int unsigned        DIV_SHIFT = 18;
    localparam int unsigned        PROD_W    = 33;
    // Quotient and frame step width: the quotient stays within +/-3277.
    localparam int unsigned        QW        = 14;

    // The frame number advances in steps of sixteen counter codes.
    localparam int unsigned FRAME_LO_W = 4;
    localparam int unsigned FRAME_STEP = 16;

    // Stream widths.
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 192;

    // Event queue between parser and arithmetic.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_HUNT1 = 2'd0,
        PH_HUNT2 = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_HDR_WORD = 2'd2
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] cnt;
    } event_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

### hw/rtl/tsfp_front.sv
// ============================================================================
// tsfp_front: byte parser
// Hunts for the two header bytes, assembles little-endian data words and
// pushes one event per finished or aborted frame.
// ============================================================================
module tsfp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_take,
    input  logic              in_op,
    input  logic [7:0]        in_byte,
    output logic              push,
    output tsfp_pkg::event_t  ev
);

    tsfp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]       idx_reg, idx_next;
    logic [7:0]       low_reg, low_next;
    logic [15:0]      wx_reg, wx_next;
    logic [15:0]      wy_reg, wy_next;

    logic        hdr;
    logic [15:0] word;
    logic [1:0]  widx;

    assign hdr  = !in_op && (in_byte == tsfp_pkg::HDR_BYTE);
    assign word = {in_byte, low_reg};
    assign widx = idx_reg[2:1];

    // Next state.
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        low_next   = low_reg;
        wx_next    = wx_reg;
        wy_next    = wy_reg;
        if (in_take)
        begin
            case (phase_reg)
                tsfp_pkg::PH_HUNT2:
                begin
                    phase_next = hdr ? tsfp_pkg::PH_DATA : tsfp_pkg::PH_HUNT1;
                    idx_next   = '0;
                end
                tsfp_pkg::PH_DATA:
                begin
                    if (in_op)
                    begin
                        phase_next = tsfp_pkg::PH_HUNT1;
                        idx_next   = '0;
                    end
                    else if (!idx_reg[0])
                    begin
                        low_next = in_byte;
                        idx_next = idx_reg + 3'd1;
                    end
                    else if (word == tsfp_pkg::HDR_WORD || widx == tsfp_pkg::LAST_WORD)
                    begin
                        phase_next = tsfp_pkg::PH_HUNT1;
                        idx_next   = '0;
                    end
                    else
                    begin
                        if (widx[0])
                        begin
                            wy_next = word;
                        end
                        else
                        begin
                            wx_next = word;
                        end
                        idx_next = idx_reg + 3'd1;
                    end
                end
                default:
                begin
                    // The unused phase code hunts like the first header phase.
                    phase_next = hdr ? tsfp_pkg::PH_HUNT2 : tsfp_pkg::PH_HUNT1;
                end
            endcase
        end
    end

    // Outputs: an event for a good frame or for an aborted one.
    always_comb
    begin
        push      = 1'b0;
        ev.status = tsfp_pkg::ST_OK;
        ev.x      = wx_reg;
        ev.y      = wy_reg;
        ev.cnt    = word;
        case (phase_reg)
            tsfp_pkg::PH_DATA:
            begin
                if (in_take && in_op)
                begin
                    push      = 1'b1;
                    ev.status = tsfp_pkg::ST_TIMEOUT;
                    ev.x      = '0;
                    ev.y      = '0;
                end
                else if (in_take && idx_reg[0])
                begin
                    if (word == tsfp_pkg::HDR_WORD)
                    begin
                        push      = 1'b1;
                        ev.status = tsfp_pkg::ST_HDR_WORD;
                        ev.x      = '0;
                        ev.y      = '0;
                    end
                    else if (widx == tsfp_pkg::LAST_WORD)
                    begin
                        push = 1'b1;
                    end
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= tsfp_pkg::PH_HUNT1;
            idx_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    // Word holds are always written before a good frame reads them.
    always_ff @(posedge clk)
    begin
        low_reg <= low_next;
        wx_reg  <= wx_next;
        wy_reg  <= wy_next;
    end

endmodule

### hw/rtl/tsfp_queue.sv
// ============================================================================
// tsfp_queue: event queue
// Small first-in first-out buffer that decouples the parser from the
// frame arithmetic and the output handshake.
// ============================================================================
module tsfp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tsfp_pkg::event_t  ev_in,
    input  logic              pop,
    output tsfp_pkg::event_t  ev_out,
    output tsfp_pkg::qstat_t  stat
);

    tsfp_pkg::event_t                 slot_reg [tsfp_pkg::QUEUE_DEPTH];
    logic [tsfp_pkg::QPTR_W-1:0]      wr_reg, wr_next;
    logic [tsfp_pkg::QPTR_W-1:0]      rd_reg, rd_next;
    logic [tsfp_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    assign stat.full  = (cnt_reg == tsfp_pkg::QCNT_W'(tsfp_pkg::QUEUE_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign ev_out     = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + tsfp_pkg::QPTR_W'(1) : wr_reg;
        rd_next  = pop ? rd_reg + tsfp_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + tsfp_pkg::QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - tsfp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= ev_in;
        end
    end

endmodule

### hw/rtl/tsfp_back.sv
// ============================================================================
// tsfp_back: frame arithmetic
// Three stages: divide the counter word by ten, extend the frame number,
// then update the running counters and hold the result for the output.
// ============================================================================
module tsfp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  tsfp_pkg::qstat_t    qstat,
    input  tsfp_pkg::event_t    ev_in,
    output logic                pop,
    input  logic                out_ready,
    output logic                out_valid,
    output tsfp_pkg::status_t   status,
    output logic [15:0]         raw_x,
    output logic [15:0]         raw_y,
    output logic [31:0]         frame_number,
    output logic [31:0]         missed_now,
    output logic [31:0]         miss_events,
    output logic [31:0]         missed_total,
    output logic [31:0]         frames_read
);

    function automatic logic [31:0] sext_q(input logic [tsfp_pkg::QW-1:0] v);
        return {{(32 - tsfp_pkg::QW){v[tsfp_pkg::QW-1]}}, v};
    endfunction

    logic go;

    // Divide stage.
    logic                                m_valid_reg, m_valid_next;
    tsfp_pkg::event_t                    m_ev_reg;
    logic signed [tsfp_pkg::PROD_W-1:0]  m_prod_reg, prod;

    // Frame stage.
    logic                     f_valid_reg, f_valid_next;
    tsfp_pkg::status_t        f_status_reg;
    logic [15:0]              f_x_reg, f_y_reg;
    logic [31:0]              f_frame_reg, f_missed_reg;
    logic                     f_miss_reg;

    // Output stage.
    logic                     out_valid_reg, out_valid_next;
    tsfp_pkg::status_t        out_status_reg;
    logic [15:0]              out_x_reg, out_y_reg;
    logic [31:0]              out_frame_reg, out_missed_reg;

    // Running state.
    logic [31:0] prev_reg, prev_next;
    logic [31:0] events_reg, events_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] frames_reg, frames_next;

    logic [tsfp_pkg::QW-1:0] q, d0, d1, dsel;
    logic [31:0]             fa, fb, frame_new, missed_new;
    logic                    less, m_ok, load_ok;

    assign go  = !out_valid_reg || out_ready;
    assign pop = go && !qstat.empty;

    assign prod = $signed(ev_in.cnt) * tsfp_pkg::DIV_MAGIC;

    // The frame number is prev with its low bits replaced by the quotient,
    // which is prev plus the narrow difference d0; a step back wraps forward
    // by sixteen.
    always_comb
    begin
        q    = m_prod_reg[tsfp_pkg::DIV_SHIFT +: tsfp_pkg::QW]
             + tsfp_pkg::QW'(m_prod_reg[tsfp_pkg::PROD_W-1]);
        d0   = q - tsfp_pkg::QW'(prev_reg[tsfp_pkg::FRAME_LO_W-1:0]);
        d1   = d0 + tsfp_pkg::QW'(tsfp_pkg::FRAME_STEP);
        fa   = prev_reg + sext_q(d0);
        fb   = prev_reg + sext_q(d1);
        less = $signed(fa) < $signed(prev_reg);
        dsel = less ? d1 : d0;
        frame_new  = less ? fb : fa;
        missed_new = (dsel == '0) ? 32'd0 : sext_q(dsel - tsfp_pkg::QW'(1));
        m_ok       = (m_ev_reg.status == tsfp_pkg::ST_OK);
    end

    always_comb
    begin
        m_valid_next   = go ? !qstat.empty : m_valid_reg;
        f_valid_next   = go ? m_valid_reg : f_valid_reg;
        out_valid_next = go ? f_valid_reg : out_valid_reg;
        prev_next      = (go && m_valid_reg && m_ok) ? frame_new : prev_reg;
        load_ok        = go && f_valid_reg && (f_status_reg == tsfp_pkg::ST_OK);
        frames_next    = load_ok ? frames_reg + 32'd1 : frames_reg;
        events_next    = (load_ok && f_miss_reg) ? events_reg + 32'd1 : events_reg;
        total_next     = (load_ok && f_miss_reg) ? total_reg + f_missed_reg : total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg   <= 1'b0;
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            events_reg    <= '0;
            total_reg     <= '0;
            frames_reg    <= '0;
        end
        else
        begin
            m_valid_reg   <= m_valid_next;
            f_valid_reg   <= f_valid_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            events_reg    <= events_next;
            total_reg     <= total_next;
            frames_reg    <= frames_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            m_ev_reg       <= ev_in;
            m_prod_reg     <= prod;
            f_status_reg   <= m_ev_reg.status;
            f_x_reg        <= m_ev_reg.x;
            f_y_reg        <= m_ev_reg.y;
            f_frame_reg    <= m_ok ? frame_new : prev_reg;
            f_missed_reg   <= m_ok ? missed_new : 32'd0;
            f_miss_reg     <= m_ok && (dsel != '0) && (dsel != tsfp_pkg::QW'(1));
            out_status_reg <= f_status_reg;
            out_x_reg      <= f_x_reg;
            out_y_reg      <= f_y_reg;
            out_frame_reg  <= f_frame_reg;
            out_missed_reg <= f_missed_reg;
        end
    end

    // Counters change only when a result loads, so they match the held result.
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign raw_x        = out_x_reg;
    assign raw_y        = out_y_reg;
    assign frame_number = out_frame_reg;
    assign missed_now   = out_missed_reg;
    assign miss_events  = events_reg;
    assign missed_total = total_reg;
    assign frames_read  = frames_reg;

endmodule

### hw/rtl/tracker_serial_frame_parser_unit.sv
// ============================================================================
// tracker_serial_frame_parser_unit: tracker serial frame parser
// Turns a stream of serial bytes and read timeouts into tracker frame
// results with an extended frame number and missed-frame statistics.
// ============================================================================
//
// Channel   Direction  tuser            tdata (lowest bit first)
// s_axis    in         operation[0]     rx_byte[7:0]
// m_axis    out        status[1:0]      raw_x, raw_y, frame_number, missed_now,
//                                       miss_events, missed_total, frames_read
//
// The block takes one request per clock cycle while the queue has room; the
// byte parser decides on each byte in the same cycle that it is taken. Each
// frame or error event then passes through a four-entry queue and a
// three-stage arithmetic pipeline before its result is shown. Reset clears
// the parser, the queue and all counters at once; there is no clearing pass.
// When the output is stalled the arithmetic holds and events collect in the
// queue; s_axis_tready falls only when the queue is full.
//
module tracker_serial_frame_parser_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // rx_byte[7:0]
    input  logic [tsfp_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // operation[0]
    input  logic [0:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // raw_x[15:0], raw_y[31:16], frame_number[63:32], missed_now[95:64],
    // miss_events[127:96], missed_total[159:128], frames_read[191:160]
    output logic [tsfp_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // status[1:0]
    output logic [1:0]                            m_axis_tuser
);

    logic              s_take;
    logic              q_push;
    logic              q_pop;
    tsfp_pkg::event_t  ev_front;
    tsfp_pkg::event_t  ev_queue;
    tsfp_pkg::qstat_t  q_stat;
    tsfp_pkg::status_t res_status;
    logic [15:0]       res_x, res_y;
    logic [31:0]       res_frame, res_missed, res_events, res_total, res_frames;

    // A request is taken whenever the queue has room, whether or not the
    // byte finishes a frame.
    assign s_axis_tready = !q_stat.full;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    tsfp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_take (s_take),
        .in_op   (s_axis_tuser[0]),
        .in_byte (s_axis_tdata),
        .push    (q_push),
        .ev      (ev_front)
    );

    tsfp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .ev_in  (ev_front),
        .pop    (q_pop),
        .ev_out (ev_queue),
        .stat   (q_stat)
    );

    tsfp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (q_stat),
        .ev_in        (ev_queue),
        .pop          (q_pop),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .status       (res_status),
        .raw_x        (res_x),
        .raw_y        (res_y),
        .frame_number (res_frame),
        .missed_now   (res_missed),
        .miss_events  (res_events),
        .missed_total (res_total),
        .frames_read  (res_frames)
    );

    assign m_axis_tuser = res_status;
    assign m_axis_tdata = {res_frames, res_total, res_events, res_missed,
                           res_frame, res_y, res_x};

`ifndef SYNTHESIS
    // The parser pushes only for a taken request, which needs queue room.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_stat.full))
        else $error("event pushed into a full queue");

    // The arithmetic never pulls from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && q_stat.empty))
        else $error("event popped from an empty queue");

    // An error result carries zero words and no missed frames.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != tsfp_pkg::ST_OK) |->
        (m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[95:64] == 32'd0))
        else $error("error result with nonzero data fields");

    // A stalled result stays offered and unchanged until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");
`endif

endmodule
